FILE: src/ole_pkg.sv
// Shared types, codes and constants for the ordered list engine.
package ole_pkg;

    // Field widths fixed by the item formats
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 4;
    localparam int POS_W        = 8;
    localparam int STAT_W       = 3;
    localparam int OUT_CNT_W    = 6;
    localparam int DEF_CAPACITY = 32;

    // Command codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 4'd0,
        FN_PUSH_FRONT = 4'd1,
        FN_POP_FRONT  = 4'd2,
        FN_POP_BACK   = 4'd3,
        FN_INS_AFTER  = 4'd4,
        FN_DEL_VALUE  = 4'd5,
        FN_DEL_POS    = 4'd6,
        FN_READ_FWD   = 4'd7,
        FN_READ_REV   = 4'd8
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BEYOND    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_READ
    } t_state;

    // Chain-wide edit applied by all cells together
    typedef enum logic [2:0] {
        ED_NONE,
        ED_INSERT,
        ED_REMOVE,
        ED_REMOVE_MATCH,
        ED_ROT_L,
        ED_ROT_R
    } t_edit;

    // Per-cell load selection
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_LOAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cap_match;
    } t_cell_ctrl;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] item_value;
        logic                     is_last;
        logic                     list_empty;
        logic [OUT_CNT_W-1:0]     entry_count;
    } t_out_item;

endpackage

FILE: src/ole_cell.sv
// One list cell: holds an entry, loads from a neighbor or new data, flags a key match.
module ole_cell (
    input  logic                              i_clk,
    input  ole_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [ole_pkg::DATA_W-1:0] i_left,
    input  logic signed [ole_pkg::DATA_W-1:0] i_right,
    input  logic signed [ole_pkg::DATA_W-1:0] i_new,
    input  logic signed [ole_pkg::DATA_W-1:0] i_key,
    output logic signed [ole_pkg::DATA_W-1:0] o_value,
    output logic                              o_match
);

    logic signed [ole_pkg::DATA_W-1:0] r_value;
    logic signed [ole_pkg::DATA_W-1:0] n_value;
    logic                              r_match;

    // Entry select
    always_comb begin
        case (i_ctrl.op)
            ole_pkg::CELL_FROM_LEFT:  n_value = i_left;
            ole_pkg::CELL_FROM_RIGHT: n_value = i_right;
            ole_pkg::CELL_LOAD:       n_value = i_new;
            default:                  n_value = r_value;
        endcase
    end

    // Entry and match flag registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctrl.cap_match) begin
            r_match <= (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

FILE: src/ordered_list_engine.sv
// Top level of the ordered list engine: sequencer, output register and the cell chain.
//
// A bounded deque of signed 32-bit entries held in a chain of CAPACITY cells,
// entry 0 at the front. Push, pop, insert-after and delete-at-position are each
// a single chain edit: every cell picks its own next entry from its neighbors in
// parallel and the status result is registered in the same cycle. Delete by
// value compares first: all cells compare against the key in S_IDLE, and the
// chain closes the gap at the first match in S_MATCH once the output is free.
// In a read-out the chain rotates by one entry per cycle while the output is
// not stalled and the end cell streams out, so the list is back in place when
// the last entry leaves. Results wait in an output register; a stalled output
// slows the sequencer but loses nothing. No clearing pass is needed after reset.
module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ole_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ole_pkg::t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    ole_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left, n_left;
    logic               r_dir, n_dir;
    logic               r_out_valid, n_out_valid;
    ole_pkg::t_out_item r_out_item, n_out_item;

    ole_pkg::t_edit                    edit;
    logic [CW-1:0]                     edit_idx;
    logic signed [ole_pkg::DATA_W-1:0] new_data;
    logic                              cap_match;
    logic                              out_free;
    logic                              in_stall;
    logic [CW-1:0]                     last_idx;
    logic [ole_pkg::POS_W-1:0]         count_ext;
    logic                              is_full;
    logic                              no_entries;

    logic signed [ole_pkg::DATA_W-1:0] cell_val   [CAPACITY];
    logic signed [ole_pkg::DATA_W-1:0] left_in    [CAPACITY];
    logic signed [ole_pkg::DATA_W-1:0] right_in   [CAPACITY];
    logic                              cell_match [CAPACITY];
    ole_pkg::t_cell_ctrl               cell_ctrl  [CAPACITY];
    logic [CAPACITY-1:0]               match_vec;
    logic [CAPACITY-1:0]               match_pre;
    logic signed [ole_pkg::DATA_W-1:0] tail_val;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_idx   = r_count - CW'(1);
    assign count_ext  = ole_pkg::POS_W'(r_count);
    assign is_full    = (r_count == CW'(CAPACITY));
    assign no_entries = (r_count == '0);
    assign tail_val   = cell_val[last_idx[IW-1:0]];

    // Sequencer: decode, status and chain edit select
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_dir       = r_dir;
        edit        = ole_pkg::ED_NONE;
        edit_idx    = '0;
        new_data    = i_in_item.value;
        cap_match   = 1'b0;
        in_stall    = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        n_out_item.status     = ole_pkg::ST_DONE;
        n_out_item.item_value = '0;
        n_out_item.is_last    = 1'b1;
        case (r_state)
            ole_pkg::S_IDLE: begin
                in_stall = !out_free;
                if (i_in_valid && out_free) begin
                    case (ole_pkg::t_func'(i_in_item.func))
                        ole_pkg::FN_PUSH_BACK, ole_pkg::FN_PUSH_FRONT: begin
                            n_out_valid = 1'b1;
                            if (is_full) begin
                                n_out_item.status = ole_pkg::ST_FULL;
                            end else begin
                                edit     = ole_pkg::ED_INSERT;
                                edit_idx = (i_in_item.func == ole_pkg::FN_PUSH_BACK) ?
                                           r_count : '0;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        ole_pkg::FN_POP_FRONT, ole_pkg::FN_POP_BACK: begin
                            n_out_valid = 1'b1;
                            if (no_entries) begin
                                n_out_item.status = ole_pkg::ST_EMPTY;
                            end else begin
                                edit     = ole_pkg::ED_REMOVE;
                                edit_idx = (i_in_item.func == ole_pkg::FN_POP_FRONT) ?
                                           '0 : last_idx;
                                n_count  = last_idx;
                            end
                        end
                        ole_pkg::FN_INS_AFTER: begin
                            n_out_valid = 1'b1;
                            if (is_full) begin
                                n_out_item.status = ole_pkg::ST_FULL;
                            end else if (no_entries) begin
                                edit    = ole_pkg::ED_INSERT;
                                n_count = r_count + CW'(1);
                            end else if (i_in_item.position >= count_ext) begin
                                n_out_item.status = ole_pkg::ST_BEYOND;
                            end else begin
                                edit     = ole_pkg::ED_INSERT;
                                edit_idx = CW'(i_in_item.position + ole_pkg::POS_W'(1));
                                n_count  = r_count + CW'(1);
                            end
                        end
                        ole_pkg::FN_DEL_VALUE: begin
                            if (no_entries) begin
                                n_out_valid       = 1'b1;
                                n_out_item.status = ole_pkg::ST_EMPTY;
                            end else begin
                                cap_match = 1'b1;
                                n_state   = ole_pkg::S_MATCH;
                            end
                        end
                        ole_pkg::FN_DEL_POS: begin
                            n_out_valid = 1'b1;
                            if (no_entries) begin
                                n_out_item.status = ole_pkg::ST_EMPTY;
                            end else if (i_in_item.position >= count_ext) begin
                                n_out_item.status = ole_pkg::ST_BEYOND;
                            end else begin
                                edit     = ole_pkg::ED_REMOVE;
                                edit_idx = CW'(i_in_item.position);
                                n_count  = last_idx;
                            end
                        end
                        ole_pkg::FN_READ_FWD, ole_pkg::FN_READ_REV: begin
                            if (!no_entries) begin
                                n_state = ole_pkg::S_READ;
                                n_left  = r_count;
                                n_dir   = (i_in_item.func == ole_pkg::FN_READ_REV);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ole_pkg::S_MATCH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ole_pkg::S_IDLE;
                    if (|match_vec) begin
                        edit    = ole_pkg::ED_REMOVE_MATCH;
                        n_count = last_idx;
                    end else begin
                        n_out_item.status = ole_pkg::ST_NOT_FOUND;
                    end
                end
            end
            ole_pkg::S_READ: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    new_data              = r_dir ? tail_val : cell_val[0];
                    edit                  = r_dir ? ole_pkg::ED_ROT_R : ole_pkg::ED_ROT_L;
                    n_out_item.item_value = new_data;
                    n_out_item.is_last    = (r_left == CW'(1));
                    n_left                = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = ole_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = ole_pkg::S_IDLE;
            end
        endcase
        n_out_item.list_empty  = (n_count == '0);
        n_out_item.entry_count = ole_pkg::OUT_CNT_W'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ole_pkg::S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_item <= n_out_item;
        end
    end

    // Cell chain with per-cell load select
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CW-1:0]       G    = CW'(g);
        localparam logic [CAPACITY-1:0] MASK = {CAPACITY{1'b1}} >> (CAPACITY - 1 - g);

        if (g == 0) begin : g_first
            assign left_in[g] = '0;
        end else begin : g_mid_l
            assign left_in[g] = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_in[g] = '0;
        end else begin : g_mid_r
            assign right_in[g] = cell_val[g+1];
        end

        // Only entries in use may match
        assign match_vec[g] = cell_match[g] && (G < r_count);
        // First match at or before this cell
        assign match_pre[g] = |(match_vec & MASK);

        always_comb begin
            cell_ctrl[g].op        = ole_pkg::CELL_HOLD;
            cell_ctrl[g].cap_match = cap_match;
            case (edit)
                ole_pkg::ED_INSERT: begin
                    if (G == edit_idx) begin
                        cell_ctrl[g].op = ole_pkg::CELL_LOAD;
                    end else if (G > edit_idx) begin
                        cell_ctrl[g].op = ole_pkg::CELL_FROM_LEFT;
                    end
                end
                ole_pkg::ED_REMOVE: begin
                    if (G >= edit_idx) begin
                        cell_ctrl[g].op = ole_pkg::CELL_FROM_RIGHT;
                    end
                end
                ole_pkg::ED_REMOVE_MATCH: begin
                    if (match_pre[g]) begin
                        cell_ctrl[g].op = ole_pkg::CELL_FROM_RIGHT;
                    end
                end
                ole_pkg::ED_ROT_L: begin
                    if (G == last_idx) begin
                        cell_ctrl[g].op = ole_pkg::CELL_LOAD;
                    end else if (G < last_idx) begin
                        cell_ctrl[g].op = ole_pkg::CELL_FROM_RIGHT;
                    end
                end
                ole_pkg::ED_ROT_R: begin
                    if (G == '0) begin
                        cell_ctrl[g].op = ole_pkg::CELL_LOAD;
                    end else if (G <= last_idx) begin
                        cell_ctrl[g].op = ole_pkg::CELL_FROM_LEFT;
                    end
                end
                default: begin
                end
            endcase
        end

        ole_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl[g]),
            .i_left  (left_in[g]),
            .i_right (right_in[g]),
            .i_new   (new_data),
            .i_key   (i_in_item.value),
            .o_value (cell_val[g]),
            .o_match (cell_match[g])
        );
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: test/ordered_list_engine_tb.sv
// Self-checking testbench for the ordered list engine: directed and random commands.
`timescale 1ns / 100ps

module ordered_list_engine_tb;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int CAPACITY       = ole_pkg::DEF_CAPACITY;
    localparam int RANDOM_ITEMS   = 348;
    localparam int CALM_ITEMS     = 60;
    localparam int PHASE_LEN      = 40;
    localparam int HOLD_AT        = 120;
    localparam int DRAIN_AT       = 200;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_MAX     = 10;

    // Command codes the block must ignore
    localparam logic [ole_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = 4'd9;
    localparam logic [ole_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

    // Command mix of one random phase
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } t_mix;

    // Tracks the list contents and the results still owed by the block
    class list_scoreboard;
        logic signed [ole_pkg::DATA_W-1:0] entries[$];
        ole_pkg::t_out_item                owed_q[$];
        int                                errors;
        int                                limit;

        function new(int cap);
            limit  = cap;
            errors = 0;
        endfunction

        function string describe(ole_pkg::t_out_item r);
            return $sformatf("status=%0d value=%0d last=%0b empty=%0b count=%0d",
                             r.status, r.item_value, r.is_last, r.list_empty,
                             r.entry_count);
        endfunction

        function void owe(logic [ole_pkg::STAT_W-1:0] st,
                          logic signed [ole_pkg::DATA_W-1:0] v, logic last);
            ole_pkg::t_out_item r;
            r.status      = st;
            r.item_value  = v;
            r.is_last     = last;
            r.list_empty  = (entries.size() == 0);
            r.entry_count = ole_pkg::OUT_CNT_W'(entries.size());
            owed_q.insert(owed_q.size(), r);
        endfunction

        // Apply one accepted command and queue the results it should cause
        function void note_transfer(ole_pkg::t_in_item it);
            int               n;
            int               pos;
            ole_pkg::t_status st;
            n   = entries.size();
            pos = int'(it.position);
            st  = ole_pkg::ST_DONE;
            case (it.func)
                ole_pkg::FN_PUSH_BACK, ole_pkg::FN_PUSH_FRONT: begin
                    if (n >= limit)
                        st = ole_pkg::ST_FULL;
                    else if (it.func == ole_pkg::FN_PUSH_BACK)
                        entries.insert(n, it.value);
                    else
                        entries.insert(0, it.value);
                end
                ole_pkg::FN_POP_FRONT, ole_pkg::FN_POP_BACK: begin
                    if (n == 0)
                        st = ole_pkg::ST_EMPTY;
                    else if (it.func == ole_pkg::FN_POP_FRONT)
                        entries.delete(0);
                    else
                        entries.delete(n - 1);
                end
                ole_pkg::FN_INS_AFTER: begin
                    // empty list takes the value whatever the position
                    if (n >= limit)
                        st = ole_pkg::ST_FULL;
                    else if (n == 0)
                        entries.insert(0, it.value);
                    else if (pos >= n)
                        st = ole_pkg::ST_BEYOND;
                    else
                        entries.insert(pos + 1, it.value);
                end
                ole_pkg::FN_DEL_VALUE: begin
                    if (n == 0) begin
                        st = ole_pkg::ST_EMPTY;
                    end else begin
                        st = ole_pkg::ST_NOT_FOUND;
                        for (int i = 0; i < n; i++) begin
                            if (entries[i] == it.value) begin
                                entries.delete(i);
                                st = ole_pkg::ST_DONE;
                                break;
                            end
                        end
                    end
                end
                ole_pkg::FN_DEL_POS: begin
                    if (n == 0)
                        st = ole_pkg::ST_EMPTY;
                    else if (pos >= n)
                        st = ole_pkg::ST_BEYOND;
                    else
                        entries.delete(pos);
                end
                ole_pkg::FN_READ_FWD, ole_pkg::FN_READ_REV: begin
                    for (int i = 0; i < n; i++)
                        owe(ole_pkg::ST_DONE,
                            entries[(it.func == ole_pkg::FN_READ_FWD) ? i : n - 1 - i],
                            i == n - 1);
                    return;
                end
                default: return;
            endcase
            owe(st, '0, 1'b1);
        endfunction

        // Compare one result transfer against the oldest owed result
        function void check_result(ole_pkg::t_out_item got);
            ole_pkg::t_out_item want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: result with none owed: %s", describe(got));
                return;
            end
            want = owed_q[0];
            owed_q.delete(0);
            if (got.status !== want.status || got.item_value !== want.item_value ||
                got.is_last !== want.is_last || got.list_empty !== want.list_empty ||
                got.entry_count !== want.entry_count) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("ERROR: expected %s", describe(want));
                    $display("       actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    ole_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_stall;
    ole_pkg::t_out_item out_item;

    list_scoreboard sb;
    bit             tx_idle_en;
    bit             rx_idle_en;
    bit             hold_req;
    int             quiet_cycles = 0;

    ordered_list_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #CLK_HALF clk = ~clk;

    // Offer one command and hold it until the block takes it
    task automatic transfer_in(ole_pkg::t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_transfer(it);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic issue(logic [ole_pkg::FUNC_W-1:0] fn,
                         logic signed [ole_pkg::DATA_W-1:0] v,
                         logic [ole_pkg::POS_W-1:0] p);
        ole_pkg::t_in_item it;
        it.func     = fn;
        it.value    = v;
        it.position = p;
        transfer_in(it);
    endtask

    // Random command shaped by the phase mix and the current list contents
    function automatic ole_pkg::t_in_item draw_command(t_mix mix);
        ole_pkg::t_in_item it;
        int                r;
        int                n;
        n = sb.entries.size();
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                it.func = r < 30 ? ole_pkg::FN_PUSH_BACK : r < 55 ? ole_pkg::FN_PUSH_FRONT :
                          r < 80 ? ole_pkg::FN_INS_AFTER : r < 85 ? ole_pkg::FN_POP_FRONT :
                          r < 90 ? ole_pkg::FN_DEL_VALUE : r < 95 ? ole_pkg::FN_READ_FWD :
                          ole_pkg::FN_READ_REV;
            MIX_DRAIN:
                it.func = r < 20 ? ole_pkg::FN_POP_FRONT : r < 40 ? ole_pkg::FN_POP_BACK :
                          r < 60 ? ole_pkg::FN_DEL_VALUE : r < 80 ? ole_pkg::FN_DEL_POS :
                          r < 87 ? ole_pkg::FN_PUSH_BACK : r < 92 ? ole_pkg::FN_INS_AFTER :
                          r < 96 ? ole_pkg::FN_READ_FWD : ole_pkg::FN_READ_REV;
            default:
                it.func = ole_pkg::FUNC_W'($urandom_range(0, int'(ole_pkg::FN_READ_REV)));
        endcase
        // deletes mostly aim at a value that is present
        if (it.func == ole_pkg::FN_DEL_VALUE && n != 0 && $urandom_range(0, 2) != 0) begin
            it.value = sb.entries[$urandom_range(0, n - 1)];
        end else begin
            case ($urandom_range(0, 9))
                0:       it.value = 32'sh7FFF_FFFF;
                1:       it.value = 32'sh8000_0000;
                2:       it.value = '0;
                3, 4:    it.value = $signed($urandom_range(0, 7)) - 4;
                default: it.value = $urandom();
            endcase
        end
        case ($urandom_range(0, 7))
            0:       it.position = ole_pkg::POS_W'($urandom_range(0, 255));
            1:       it.position = ole_pkg::POS_W'(n);
            default: it.position = (n == 0) ? '0 : ole_pkg::POS_W'($urandom_range(0, n - 1));
        endcase
        return it;
    endfunction

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin : out_stall_drive
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check every result transfer
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(out_item);
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) ||
            (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_mix mix;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_req     = 1'b0;
        mix          = MIX_FILL;
        sb           = new(CAPACITY);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, extremes, position limits, ignored codes
        issue(ole_pkg::FN_READ_FWD, 0, 0);
        issue(ole_pkg::FN_POP_FRONT, 0, 0);
        issue(ole_pkg::FN_POP_BACK, 0, 0);
        issue(ole_pkg::FN_DEL_VALUE, 0, 0);
        issue(ole_pkg::FN_DEL_POS, 0, 0);
        issue(ole_pkg::FN_INS_AFTER, 5, 8'hFF);
        issue(ole_pkg::FN_PUSH_BACK, 32'sh7FFF_FFFF, 0);
        issue(ole_pkg::FN_PUSH_FRONT, 32'sh8000_0000, 0);
        issue(ole_pkg::FN_INS_AFTER, 7, 3);
        issue(ole_pkg::FN_INS_AFTER, -1, 2);
        issue(ole_pkg::FN_INS_AFTER, 0, 0);
        issue(ole_pkg::FN_READ_FWD, 0, 0);
        issue(ole_pkg::FN_READ_REV, 0, 0);
        issue(ole_pkg::FN_DEL_VALUE, 12345, 0);
        issue(ole_pkg::FN_DEL_VALUE, -1, 0);
        issue(ole_pkg::FN_DEL_POS, 0, 8'hFF);
        issue(ole_pkg::FN_DEL_POS, 0, 1);
        issue(FUNC_UNUSED_LO, 32'sh5555_5555, 8'hAA);
        issue(FUNC_UNUSED_HI, 32'shAAAA_AAAA, 8'h55);
        issue(ole_pkg::FN_POP_FRONT, 0, 0);
        issue(ole_pkg::FN_POP_BACK, 0, 0);
        issue(ole_pkg::FN_READ_REV, 0, 0);

        // Random phases: two fills toward a full list, a drain, a fill, then random mixes
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % PHASE_LEN == 0) begin
                case (k / PHASE_LEN)
                    0, 1, 3: mix = MIX_FILL;
                    2:       mix = MIX_DRAIN;
                    default: mix = t_mix'($urandom_range(0, 2));
                endcase
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            // long receiver hold-off while the sender keeps offering
            if (k == HOLD_AT) begin
                tx_idle_en = 1'b0;
                hold_req   = 1'b1;
            end
            // sender pause until the block has delivered everything
            if (k == DRAIN_AT) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.owed_q.size() != 0) @(posedge clk);
            end
            if (k >= RANDOM_ITEMS - CALM_ITEMS) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (mix == MIX_ANY && $urandom_range(0, 15) == 0)
                issue(ole_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)),
                      $urandom(), ole_pkg::POS_W'($urandom_range(0, 255)));
            transfer_in(draw_command(mix));
        end
        in_valid <= 1'b0;

        // Drain, then let any trailing activity show up
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/ole_pkg.sv
src/ole_cell.sv
src/ordered_list_engine.sv
test/ordered_list_engine_tb.sv
